### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tlpw_pkg.sv
// ----------------------------------------------------------------------------
// tlpw_pkg
// Types and constants shared by the page walk memories, walker and top level.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  // Store sizes and address widths
  localparam int MEM_BYTES  = 4096;
  localparam int DISK_BYTES = 4096;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int DISK_AW    = $clog2(DISK_BYTES);
  localparam int BYTE_W     = 8;

  // Clearing pass covers the larger store
  localparam int CLEAR_LEN  = (MEM_BYTES > DISK_BYTES) ? MEM_BYTES : DISK_BYTES;
  localparam int CLR_W      = $clog2(CLEAR_LEN);

  // Virtual address split
  localparam int VA_W    = 15;
  localparam int OFF_W   = 5;
  localparam int TIDX_W  = 5;
  localparam int DIDX_W  = 5;
  localparam int FRAME_W = 7;
  localparam int VALID_BIT = 7;

  localparam logic [MEM_AW-1:0] DIR_BASE_RESET = 12'hD80;

  typedef enum logic [1:0] {
    CMD_MEM_WR  = 2'd0,
    CMD_DISK_WR = 2'd1,
    CMD_XLATE   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_MEM   = 2'd0,
    ST_FAULT = 2'd1,
    ST_DISK  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    WS_CLEAR,
    WS_IDLE,
    WS_DIR,
    WS_TBL,
    WS_DATA
  } walk_state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [MEM_AW-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [DISK_AW-1:0] addr;
    logic [BYTE_W-1:0]  wdata;
  } disk_req_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } walk_status_t;

  typedef struct packed {
    status_t            status;
    logic [DIDX_W-1:0]  dir_index;
    logic               dir_valid;
    logic [FRAME_W-1:0] table_frame;
    logic [TIDX_W-1:0]  table_index;
    logic               page_valid;
    logic [FRAME_W-1:0] page_frame;
    logic [MEM_AW-1:0]  target_addr;
    logic [BYTE_W-1:0]  value;
  } result_t;

endpackage

### sv/two_level_page_walk.sv
// ----------------------------------------------------------------------------
// two_level_page_walk
// Byte memory and disk store with a two-level page table walk on translate.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes both stores with the input stalled;
// dir_base writes are taken throughout. A load item is written as it is
// accepted. A translate item is accepted and then makes three dependent reads
// through the single port of the memories (directory entry, page table entry,
// data byte), each read registered in the RAM; a directory fault ends after
// the directory read. The result waits in an output register; a new item is
// taken once that register is empty or being drained.
module two_level_page_walk import tlpw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [MEM_AW-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [VA_W-1:0]    in_addr,
  input  logic [BYTE_W-1:0]  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [DIDX_W-1:0]  out_dir_index,
  output logic               out_dir_valid,
  output logic [FRAME_W-1:0] out_table_frame,
  output logic [TIDX_W-1:0]  out_table_index,
  output logic               out_page_valid,
  output logic [FRAME_W-1:0] out_page_frame,
  output logic [MEM_AW-1:0]  out_target_addr,
  output logic [BYTE_W-1:0]  out_value
);

`include "assert_macros.svh"

  mem_req_t          mem_req;
  disk_req_t         disk_req;
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] disk_rdata;
  logic              res_valid;
  result_t           res;
  walk_status_t      stat;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;
  logic              out_busy;

  assign out_busy = out_valid_r && out_stall;

  tlpw_ram #(.DEPTH(MEM_BYTES), .AW(MEM_AW), .DW(BYTE_W)) u_mem (
    .clk     (clk),
    .we      (mem_req.we),
    .re      (mem_req.re),
    .addr    (mem_req.addr),
    .wdata   (mem_req.wdata),
    .rdata_r (mem_rdata)
  );

  tlpw_ram #(.DEPTH(DISK_BYTES), .AW(DISK_AW), .DW(BYTE_W)) u_disk (
    .clk     (clk),
    .we      (disk_req.we),
    .re      (disk_req.re),
    .addr    (disk_req.addr),
    .wdata   (disk_req.wdata),
    .rdata_r (disk_rdata)
  );

  tlpw_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_addr    (in_addr),
    .in_data    (in_data),
    .out_busy   (out_busy),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .disk_req   (disk_req),
    .disk_rdata (disk_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .stat       (stat)
  );

  // Output register: load a new item, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (res_valid) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_dir_index   = out_r.dir_index;
  assign out_dir_valid   = out_r.dir_valid;
  assign out_table_frame = out_r.table_frame;
  assign out_table_index = out_r.table_index;
  assign out_page_valid  = out_r.page_valid;
  assign out_page_frame  = out_r.page_frame;
  assign out_target_addr = out_r.target_addr;
  assign out_value       = out_r.value;

  // Checks
  `ASSERT_IMPLIES(a_res_into_free_reg, res_valid, !out_valid_r, "result overwrites held item")
  `ASSERT_IMPLIES(a_no_accept_clearing, stat.clearing, in_stall, "item accepted while clearing")
  `ASSERT_IMPLIES(a_fault_zero, res_valid && (res.status == ST_FAULT), !res.page_valid && (res.target_addr == '0) && (res.value == '0), "fault result carries data")
  `ASSERT_NEXT(a_walk_busy, in_valid && !in_stall && (in_cmd == CMD_XLATE), in_stall && stat.busy, "walk not busy after translate")

endmodule

### sv/tlpw_ram.sv
// ----------------------------------------------------------------------------
// tlpw_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tlpw_ram import tlpw_pkg::*; #(
  parameter int DEPTH = MEM_BYTES,
  parameter int AW    = MEM_AW,
  parameter int DW    = BYTE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem_q [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem_q[addr];
    end
  end

endmodule

### sv/tlpw_walker.sv
// ----------------------------------------------------------------------------
// tlpw_walker
// Sequencer for loads, the clearing pass and the three-read table walk.
// ----------------------------------------------------------------------------
module tlpw_walker import tlpw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [MEM_AW-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [VA_W-1:0]     in_addr,
  input  logic [BYTE_W-1:0]   in_data,
  input  logic                out_busy,
  output mem_req_t            mem_req,
  input  logic [BYTE_W-1:0]   mem_rdata,
  output disk_req_t           disk_req,
  input  logic [BYTE_W-1:0]   disk_rdata,
  output logic                res_valid,
  output result_t             res,
  output walk_status_t        stat
);

  walk_state_t        state_r, state_nxt;
  logic [CLR_W-1:0]   clr_r;
  logic [MEM_AW-1:0]  dir_base_r;
  logic [DIDX_W-1:0]  didx_r;
  logic [TIDX_W-1:0]  tidx_r;
  logic [OFF_W-1:0]   off_r;
  logic [FRAME_W-1:0] dframe_r;
  logic               pvalid_r;
  logic [FRAME_W-1:0] pframe_r;
  logic               accept;
  logic               clr_last;

  assign in_stall = (state_r != WS_IDLE) || out_busy;
  assign accept   = in_valid && !in_stall;
  assign clr_last = (clr_r == CLR_W'(CLEAR_LEN - 1));

  assign stat.clearing = (state_r == WS_CLEAR);
  assign stat.busy     = (state_r != WS_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      WS_CLEAR: begin
        if (clr_last) state_nxt = WS_IDLE;
      end
      WS_IDLE: begin
        if (accept && (in_cmd == CMD_XLATE)) state_nxt = WS_DIR;
      end
      WS_DIR: begin
        state_nxt = mem_rdata[VALID_BIT] ? WS_TBL : WS_IDLE;
      end
      WS_TBL: begin
        state_nxt = WS_DATA;
      end
      WS_DATA: begin
        state_nxt = WS_IDLE;
      end
      default: state_nxt = WS_CLEAR;
    endcase
  end

  // Memory requests and result
  always_comb begin
    mem_req   = '0;
    disk_req  = '0;
    res_valid = 1'b0;
    res.status      = ST_FAULT;
    res.dir_index   = didx_r;
    res.dir_valid   = 1'b0;
    res.table_frame = mem_rdata[FRAME_W-1:0];
    res.table_index = tidx_r;
    res.page_valid  = 1'b0;
    res.page_frame  = '0;
    res.target_addr = '0;
    res.value       = '0;
    case (state_r)
      WS_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r[MEM_AW-1:0];
        disk_req.we   = 1'b1;
        disk_req.addr = clr_r[DISK_AW-1:0];
      end
      WS_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_MEM_WR: begin
              mem_req.we    = 1'b1;
              mem_req.addr  = in_addr[MEM_AW-1:0];
              mem_req.wdata = in_data;
            end
            CMD_DISK_WR: begin
              disk_req.we    = 1'b1;
              disk_req.addr  = in_addr[DISK_AW-1:0];
              disk_req.wdata = in_data;
            end
            CMD_XLATE: begin
              mem_req.re   = 1'b1;
              mem_req.addr = dir_base_r
                           + MEM_AW'(in_addr[OFF_W+TIDX_W +: DIDX_W]);
            end
            default: ;
          endcase
        end
      end
      WS_DIR: begin
        // Valid directory entry: fetch the page table entry, else fault
        if (mem_rdata[VALID_BIT]) begin
          mem_req.re   = 1'b1;
          mem_req.addr = MEM_AW'({mem_rdata[FRAME_W-1:0], tidx_r});
        end else begin
          res_valid = 1'b1;
        end
      end
      WS_TBL: begin
        // Resident page reads memory, others read the disk
        if (mem_rdata[VALID_BIT]) begin
          mem_req.re   = 1'b1;
          mem_req.addr = MEM_AW'({mem_rdata[FRAME_W-1:0], off_r});
        end else begin
          disk_req.re   = 1'b1;
          disk_req.addr = DISK_AW'({mem_rdata[FRAME_W-1:0], off_r});
        end
      end
      WS_DATA: begin
        res_valid       = 1'b1;
        res.dir_valid   = 1'b1;
        res.table_frame = dframe_r;
        res.page_valid  = pvalid_r;
        res.page_frame  = pframe_r;
        if (pvalid_r) begin
          res.status      = ST_MEM;
          res.target_addr = MEM_AW'({pframe_r, off_r});
          res.value       = mem_rdata;
        end else begin
          res.status      = ST_DISK;
          res.target_addr = MEM_AW'(DISK_AW'({pframe_r, off_r}));
          res.value       = disk_rdata;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= WS_CLEAR;
      clr_r      <= '0;
      dir_base_r <= DIR_BASE_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == WS_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) dir_base_r <= cfg_wdata;
    end
  end

  // Hold walk fields between reads
  always_ff @(posedge clk) begin
    if (accept) begin
      didx_r <= in_addr[OFF_W+TIDX_W +: DIDX_W];
      tidx_r <= in_addr[OFF_W +: TIDX_W];
      off_r  <= in_addr[OFF_W-1:0];
    end
    if (state_r == WS_DIR) dframe_r <= mem_rdata[FRAME_W-1:0];
    if (state_r == WS_TBL) begin
      pvalid_r <= mem_rdata[VALID_BIT];
      pframe_r <= mem_rdata[FRAME_W-1:0];
    end
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Two-level page walk testbench
// Loads page directories, page tables and data bytes into the memory and disk
// stores, then translates virtual addresses and checks every field of each
// result against a predictor that keeps its own copy of both stores and of
// dir_base. Both sides of the handshake idle and stall at random.
// ----------------------------------------------------------------------------
module testbench import tlpw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code with no meaning; the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Translation scoreboard: store images, dir_base and pending results
  // --------------------------------------------------------------------------
  class xlate_scoreboard;
    logic [7:0]  mem_bytes [0:MEM_BYTES-1];
    logic [7:0]  disk_bytes [0:DISK_BYTES-1];
    logic [11:0] dir_base;
    result_t     walk_q[$];
    int          errors;
    int          n_loads, n_ignored, n_mem, n_disk, n_fault;

    function new();
      foreach (mem_bytes[i]) mem_bytes[i] = '0;
      foreach (disk_bytes[i]) disk_bytes[i] = '0;
      dir_base = DIR_BASE_RESET;
    endfunction

    // Apply a load or predict the outcome of a translation
    function void note_item(logic [1:0] cmd, logic [14:0] addr, logic [7:0] data);
      logic [4:0]  offset;
      logic [4:0]  tidx;
      logic [4:0]  didx;
      logic [7:0]  pde;
      logic [7:0]  pte;
      logic [11:0] slot;
      result_t     r;
      case (cmd)
        CMD_MEM_WR: begin
          mem_bytes[addr[11:0]] = data;
          n_loads++;
        end
        CMD_DISK_WR: begin
          disk_bytes[addr[11:0]] = data;
          n_loads++;
        end
        CMD_XLATE: begin
          offset = addr[4:0];
          tidx   = addr[9:5];
          didx   = addr[14:10];
          slot   = dir_base + 12'(didx);
          pde    = mem_bytes[slot];
          r = '0;
          r.status      = ST_FAULT;
          r.dir_index   = didx;
          r.dir_valid   = pde[7];
          r.table_frame = pde[6:0];
          r.table_index = tidx;
          if (pde[7]) begin
            pte = mem_bytes[{pde[6:0], tidx}];
            r.page_valid  = pte[7];
            r.page_frame  = pte[6:0];
            r.target_addr = {pte[6:0], offset};
            if (pte[7]) begin
              r.status = ST_MEM;
              r.value  = mem_bytes[r.target_addr];
              n_mem++;
            end else begin
              r.status = ST_DISK;
              r.value  = disk_bytes[r.target_addr];
              n_disk++;
            end
          end else begin
            n_fault++;
          end
          walk_q.push_back(r);
        end
        default: n_ignored++;
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    // Match a result against the oldest pending translation
    function void check_result(result_t got);
      result_t exp;
      if (walk_q.size() == 0) begin
        $error("result with no translation pending");
        errors++;
        return;
      end
      exp = walk_q.pop_front();
      compare_field("status",      exp.status,      got.status);
      compare_field("dir_index",   exp.dir_index,   got.dir_index);
      compare_field("dir_valid",   exp.dir_valid,   got.dir_valid);
      compare_field("table_frame", exp.table_frame, got.table_frame);
      compare_field("table_index", exp.table_index, got.table_index);
      compare_field("page_valid",  exp.page_valid,  got.page_valid);
      compare_field("page_frame",  exp.page_frame,  got.page_frame);
      compare_field("target_addr", exp.target_addr, got.target_addr);
      compare_field("value",       exp.value,       got.value);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [MEM_AW-1:0]  cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic [VA_W-1:0]    in_addr;
  logic [BYTE_W-1:0]  in_data;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [DIDX_W-1:0]  out_dir_index;
  logic               out_dir_valid;
  logic [FRAME_W-1:0] out_table_frame;
  logic [TIDX_W-1:0]  out_table_index;
  logic               out_page_valid;
  logic [FRAME_W-1:0] out_page_frame;
  logic [MEM_AW-1:0]  out_target_addr;
  logic [BYTE_W-1:0]  out_value;

  xlate_scoreboard sb;
  result_t         seen;
  int              gap_max;
  int              burst_left;
  int              stall_mode;
  int              stall_run;
  int              stall_tick;
  int              n_cfg;

  two_level_page_walk uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_addr         (in_addr),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_dir_index   (out_dir_index),
    .out_dir_valid   (out_dir_valid),
    .out_table_frame (out_table_frame),
    .out_table_index (out_table_index),
    .out_page_valid  (out_page_valid),
    .out_page_frame  (out_page_frame),
    .out_target_addr (out_target_addr),
    .out_value       (out_value)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit; allows for the clearing pass and the slowest handshakes
  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stall the result side on the pattern of the current mode
  always @(posedge clk) begin
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ((stall_tick % 7) < 3);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_run = $urandom_range(5, 30);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  // Check each result item as it is accepted
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.status      = status_t'(out_status);
      seen.dir_index   = out_dir_index;
      seen.dir_valid   = out_dir_valid;
      seen.table_frame = out_table_frame;
      seen.table_index = out_table_index;
      seen.page_valid  = out_page_valid;
      seen.page_frame  = out_page_frame;
      seen.target_addr = out_target_addr;
      seen.value       = out_value;
      sb.check_result(seen);
    end
  end

  // Drive one item, idling first when gaps are enabled and the current burst is used up
  task automatic send_item(input logic [1:0] cmd, input logic [14:0] addr,
                           input logic [7:0] data);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_addr  <= addr;
    in_data  <= data;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, addr, data);
  endtask

  // Hold the input until every pending result has come, then let loads settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.walk_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dir_base(input logic [11:0] base);
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.dir_base = base;
    n_cfg++;
  endtask

  // One phase: build directories, tables and data, then walk them with noise
  task automatic run_phase(input logic [11:0] base, input int gaps, input int stalls);
    logic [9:0]  walk_q[$];
    logic [14:0] hot_q[$];
    logic [11:0] slot;
    logic [4:0]  didx;
    logic [4:0]  tidx;
    logic [4:0]  offset;
    logic [6:0]  frame;
    logic [6:0]  pfn;
    logic        dvalid;
    logic        pvalid;
    logic [9:0]  prefix;
    int          n_dirs;
    int          done;
    int          pick;
    drain();
    gap_max    = gaps;
    stall_mode = stalls;
    write_dir_base(base);
    n_dirs = $urandom_range(3, 6);
    for (int d = 0; d < n_dirs; d++) begin
      didx   = 5'($urandom);
      frame  = 7'($urandom);
      dvalid = ($urandom_range(0, 9) != 0);
      slot   = base + 12'(didx);
      send_item(CMD_MEM_WR, {3'($urandom), slot}, {dvalid, frame});
      if (dvalid) begin
        for (int t = 0; t < 5; t++) begin
          tidx   = 5'($urandom);
          pfn    = 7'($urandom);
          pvalid = ($urandom_range(0, 2) != 0);
          send_item(CMD_MEM_WR, {3'($urandom), frame, tidx}, {pvalid, pfn});
          walk_q.push_back({didx, tidx});
          for (int k = 0; k < 2; k++) begin
            offset = 5'($urandom);
            send_item(pvalid ? CMD_MEM_WR : CMD_DISK_WR, {3'($urandom), pfn, offset},
                      8'($urandom));
            hot_q.push_back({didx, tidx, offset});
          end
        end
      end
    end
    // Mixed translations and loads; unused commands do not advance the count
    done = 0;
    while (done < 130) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && hot_q.size() > 0) begin
        send_item(CMD_XLATE, hot_q[$urandom_range(0, hot_q.size() - 1)], 8'($urandom));
        done++;
      end else if (pick < 70 && walk_q.size() > 0) begin
        prefix = walk_q[$urandom_range(0, walk_q.size() - 1)];
        send_item(CMD_XLATE, {prefix, 5'($urandom)}, 8'($urandom));
        done++;
      end else if (pick < 82) begin
        send_item(CMD_XLATE, 15'($urandom), 8'($urandom));
        done++;
      end else if (pick < 96) begin
        send_item(($urandom_range(0, 1) == 1) ? CMD_DISK_WR : CMD_MEM_WR,
                  15'($urandom), 8'($urandom));
        done++;
      end else begin
        send_item(CMD_UNUSED, 15'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_cmd     = '0;
    in_addr    = '0;
    in_data    = '0;
    out_stall  = 1'b0;
    gap_max    = 4;
    burst_left = 0;
    stall_mode = 1;
    stall_run  = 0;
    stall_tick = 0;
    n_cfg      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: faults on cleared memory with the reset dir_base
    send_item(CMD_XLATE, 15'h0000, 8'hFF);
    send_item(CMD_XLATE, 15'h7FFF, 8'h00);
    // Directory 1 -> frame 5; table 2 valid -> page 127; table 3 on disk
    send_item(CMD_MEM_WR, 15'h0D81, 8'h85);
    send_item(CMD_MEM_WR, 15'd162, 8'hFF);
    send_item(CMD_MEM_WR, 15'h7FFF, 8'hFF);
    send_item(CMD_XLATE, 15'h045F, 8'h00);
    send_item(CMD_MEM_WR, 15'd163, 8'h7F);
    send_item(CMD_DISK_WR, 15'h7FFF, 8'hA5);
    send_item(CMD_XLATE, 15'h047F, 8'h00);
    // Empty table entry falls through to disk page 0
    send_item(CMD_XLATE, 15'h0480, 8'h00);
    send_item(CMD_UNUSED, 15'h7FFF, 8'hFF);
    send_item(CMD_MEM_WR, 15'h0000, 8'h00);
    send_item(CMD_DISK_WR, 15'h0000, 8'h5A);
    send_item(CMD_XLATE, 15'h0480, 8'h00);
    // Directory 2 -> frame 0, table read from the bottom of memory
    send_item(CMD_MEM_WR, 15'h0D82, 8'h80);
    send_item(CMD_XLATE, 15'h0805, 8'h00);

    // Directory at the top of memory wraps around to address 0
    drain();
    write_dir_base(12'hFFF);
    send_item(CMD_XLATE, 15'h0400, 8'h00);
    send_item(CMD_MEM_WR, 15'h0000, 8'h85);
    send_item(CMD_XLATE, 15'h045F, 8'h00);
    send_item(CMD_XLATE, 15'h03FF, 8'h00);
    drain();
    write_dir_base(12'h000);
    send_item(CMD_XLATE, 15'h005F, 8'h00);

    // Random phases over several directory bases and idle patterns
    run_phase(12'h000, 3, 1);
    run_phase(12'hFFF, 0, 0);
    run_phase(DIR_BASE_RESET, 12, 3);
    run_phase(12'($urandom), 6, 2);
    run_phase(12'hFE0, 0, 3);
    run_phase(12'($urandom), 12, 1);
    run_phase(12'($urandom), 2, 0);

    drain();
    $display("Covered %0d loads, %0d ignored items and %0d translations",
             sb.n_loads, sb.n_ignored, sb.n_mem + sb.n_disk + sb.n_fault);
    $display("  (%0d from memory, %0d from disk, %0d faults) over %0d dir_base settings",
             sb.n_mem, sb.n_disk, sb.n_fault, n_cfg);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/tlpw_pkg.sv
sv/tlpw_ram.sv
sv/tlpw_walker.sv
sv/two_level_page_walk.sv
bench/testbench.sv
